// ===== rtl/core/icfc_pkg.sv =====
`timescale 1ns / 1ps

package icfc_pkg;

   localparam int ADC_WIDTH = 8;

   localparam logic [8:0] LIM_MIN   = 9'd18;
   localparam logic [8:0] LIM_START = 9'd60;
   localparam logic [8:0] LIM_STEP  = 9'd5;
   localparam logic [8:0] LIM_HWMAX = 9'd400;
   localparam logic [7:0] CODE_LO   = 8'd21;
   localparam logic [7:0] CODE_HI   = 8'd191;

   localparam logic [7:0]  MAX_CODE_RST  = 8'd21;
   localparam logic [7:0]  DROOP_RST     = 8'd16;
   localparam logic [7:0]  MIN_VBUS_RST  = 8'd160;
   localparam logic [15:0] DETACH_MS_RST = 16'd5000;

   localparam logic [1:0] REG_MAX_INPUT_CODE  = 2'd0;
   localparam logic [1:0] REG_DROOP_THRESHOLD = 2'd1;
   localparam logic [1:0] REG_MIN_VBUS_CODE   = 2'd2;
   localparam logic [1:0] REG_DETACH_MS       = 2'd3;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_ACCESS   = 2'd1;
   localparam logic [1:0] ERR_VBUS_LOW = 2'd2;

   localparam logic [2:0] STATE_IDLE = 3'd0;

   typedef struct packed {
      logic                 vbus_present;
      logic                 charging_bit;
      logic [ADC_WIDTH-1:0] vbus_code;
      logic [ADC_WIDTH-1:0] ibus_code;
      logic                 access_error;
      logic [15:0]          elapsed_ms;
   } req_type;

   typedef struct packed {
      logic       input_enabled;
      logic [7:0] limit_code;
      logic [8:0] applied_limit;
      logic [2:0] loop_state;
      logic       fast_poll;
      logic [1:0] error_code;
      logic [7:0] report_vbus;
      logic [7:0] report_ibus;
      logic [1:0] report_status;
   } rsp_type;

endpackage

// ===== rtl/core/input_current_foldback_controller_unit.sv =====
`timescale 1ns / 1ps

// Adaptive input current limit: each transfer on req_ is one poll tick and
// yields exactly one transfer on rsp_ carrying the limit register code, the
// applied limit in 5 mA units, the loop state, the next poll interval and the
// readings of the tick. A tick passes through one input register and one
// result register: the input register takes it, and its result moves into
// the result register once that register is empty or its result transfers;
// a new tick is taken every cycle while rsp_stall is low. The foldback state is
// updated in the same cycle that writes the result register. Write the csr_
// registers only while no tick is in flight; a new max_input_code takes
// effect at the next session reload after a detach.
module input_current_foldback_controller_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  icfc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output icfc_pkg::rsp_type rsp_data,
   input  logic             csr_write_en,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_wdata
);
   import icfc_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_NOLOAD   = 3'd1,
      PH_PROBE    = 3'd2,
      PH_DEBOUNCE = 3'd3,
      PH_SETTLE   = 3'd4
   } phase_type;

   function automatic logic [8:0] prog_limit(input logic [8:0] req);
      logic [8:0] r;
      r = req;
      if (r < LIM_MIN) r = LIM_MIN;
      if (r > LIM_HWMAX) r = LIM_HWMAX;
      if (req == 9'd0) r = 9'd0;
      return {r[8:1], 1'b0};
   endfunction

   logic [7:0]  max_code_ff;
   logic [7:0]  droop_ff;
   logic [7:0]  min_vbus_ff;
   logic [15:0] detach_ff;

   logic        s1_valid_ff;
   req_type     s1_data_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;
   rsp_type     rsp_data_in;

   phase_type   phase_ff, phase_in;
   logic [8:0]  target_ff, target_in;
   logic [8:0]  applied_ff, applied_in;
   logic [8:0]  session_ff, session_in;
   logic [ADC_WIDTH-1:0] noload_ff, noload_in;
   logic        absent_ff, absent_in;
   logic [15:0] atime_ff, atime_in;

   logic        advance;
   logic        take;
   logic [7:0]  code_clamp;
   logic [8:0]  decoded_max;
   logic [16:0] absent_sum;
   logic [15:0] atime_sat;
   logic        reload;
   logic [8:0]  session_mid;
   logic        drooped;
   logic [8:0]  start_lim;
   logic [8:0]  step_sum;
   logic [8:0]  step_req;
   logic [8:0]  lower_req;
   logic [8:0]  lower_app;
   logic [1:0]  ecode;
   logic        fast;
   logic [7:0]  rv;
   logic [7:0]  ri;
   logic [1:0]  rs;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign take      = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign code_clamp  = (max_code_ff < CODE_LO) ? CODE_LO :
                        (max_code_ff > CODE_HI) ? CODE_HI : max_code_ff;
   assign decoded_max = LIM_MIN + {code_clamp, 1'b0};

   assign absent_sum  = {1'b0, atime_ff} + {1'b0, s1_data_ff.elapsed_ms};
   assign atime_sat   = absent_sum[16] ? 16'hFFFF : absent_sum[15:0];
   assign reload      = !s1_data_ff.access_error && absent_ff && (atime_sat > detach_ff);
   assign session_mid = reload ? decoded_max : session_ff;

   assign drooped = (noload_ff > s1_data_ff.vbus_code) &&
                    ((noload_ff - s1_data_ff.vbus_code) > ADC_WIDTH'(droop_ff));

   assign start_lim = (session_mid < LIM_START) ? session_mid : LIM_START;
   assign step_sum  = target_ff + LIM_STEP;
   assign step_req  = (step_sum > session_mid) ? session_mid : step_sum;
   assign lower_req = (target_ff <= LIM_MIN) ? 9'd0 :
                      ((target_ff - LIM_STEP) < LIM_MIN) ? LIM_MIN : (target_ff - LIM_STEP);
   assign lower_app = prog_limit(lower_req);

   always_comb begin
      phase_in   = phase_ff;
      target_in  = target_ff;
      applied_in = applied_ff;
      session_in = session_mid;
      noload_in  = noload_ff;
      absent_in  = absent_ff;
      atime_in   = atime_ff;
      ecode      = ERR_NONE;
      fast       = 1'b0;
      rv         = 8'd0;
      ri         = 8'd0;
      rs         = 2'd0;
      if (s1_data_ff.access_error) begin
         ecode      = ERR_ACCESS;
         applied_in = 9'd0;
         phase_in   = PH_IDLE;
         target_in  = 9'd0;
      end else if (!s1_data_ff.vbus_present) begin
         applied_in = 9'd0;
         phase_in   = PH_IDLE;
         target_in  = 9'd0;
         absent_in  = 1'b1;
         atime_in   = absent_ff ? atime_sat : 16'd0;
         rs         = {s1_data_ff.charging_bit, 1'b0};
      end else begin
         if (absent_ff) begin
            atime_in = atime_sat;
         end
         absent_in = 1'b0;
         rs        = {s1_data_ff.charging_bit, 1'b1};
         if (phase_ff != PH_IDLE && s1_data_ff.vbus_code < ADC_WIDTH'(min_vbus_ff)) begin
            ecode      = ERR_VBUS_LOW;
            applied_in = 9'd0;
            phase_in   = PH_IDLE;
            target_in  = 9'd0;
            rs         = 2'd0;
         end else begin
            if (phase_ff != PH_IDLE) begin
               rv = s1_data_ff.vbus_code[7:0];
               if (phase_ff != PH_NOLOAD) begin
                  ri = s1_data_ff.ibus_code[7:0];
               end
            end
            unique case (phase_ff)
               PH_NOLOAD: begin
                  noload_in  = s1_data_ff.vbus_code;
                  target_in  = start_lim;
                  applied_in = prog_limit(start_lim);
                  phase_in   = PH_PROBE;
                  fast       = 1'b1;
               end
               PH_PROBE: begin
                  if (drooped) begin
                     phase_in = PH_DEBOUNCE;
                  end else if (applied_ff >= session_mid) begin
                     phase_in = PH_SETTLE;
                  end else begin
                     applied_in = prog_limit(step_req);
                     target_in  = step_req;
                  end
                  fast = 1'b1;
               end
               PH_DEBOUNCE: begin
                  if (drooped) begin
                     applied_in = lower_app;
                     target_in  = lower_req;
                     phase_in   = (lower_app != 9'd0) ? PH_SETTLE : PH_NOLOAD;
                  end else begin
                     phase_in = PH_PROBE;
                  end
                  fast = 1'b1;
               end
               PH_SETTLE: begin
                  if (drooped) begin
                     applied_in = lower_app;
                     target_in  = lower_req;
                     if (lower_app == 9'd0) begin
                        phase_in = PH_NOLOAD;
                     end
                  end else if (target_ff != 9'd0 && target_ff < session_mid) begin
                     session_in = target_ff;
                  end
               end
               default: begin
                  applied_in = 9'd0;
                  phase_in   = PH_NOLOAD;
                  fast       = 1'b1;
               end
            endcase
         end
      end

      rsp_data_in.input_enabled = (applied_in != 9'd0);
      rsp_data_in.limit_code    = (applied_in != 9'd0) ?
                                  8'((applied_in - LIM_MIN) >> 1) : 8'd0;
      rsp_data_in.applied_limit = applied_in;
      rsp_data_in.loop_state    = phase_in;
      rsp_data_in.fast_poll     = fast;
      rsp_data_in.error_code    = ecode;
      rsp_data_in.report_vbus   = rv;
      rsp_data_in.report_ibus   = ri;
      rsp_data_in.report_status = rs;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_code_ff  <= MAX_CODE_RST;
         droop_ff     <= DROOP_RST;
         min_vbus_ff  <= MIN_VBUS_RST;
         detach_ff    <= DETACH_MS_RST;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         target_ff    <= 9'd0;
         applied_ff   <= 9'd0;
         session_ff   <= LIM_MIN + {MAX_CODE_RST, 1'b0};
         noload_ff    <= '0;
         absent_ff    <= 1'b0;
         atime_ff     <= 16'd0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               REG_MAX_INPUT_CODE:  max_code_ff <= csr_wdata[7:0];
               REG_DROOP_THRESHOLD: droop_ff    <= csr_wdata[7:0];
               REG_MIN_VBUS_CODE:   min_vbus_ff <= csr_wdata[7:0];
               REG_DETACH_MS:       detach_ff   <= csr_wdata;
               default:             detach_ff   <= detach_ff;
            endcase
         end
         if (take) begin
            s1_valid_ff <= 1'b1;
            s1_data_ff  <= req_data;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= rsp_data_in;
            phase_ff     <= phase_in;
            target_ff    <= target_in;
            applied_ff   <= applied_in;
            session_ff   <= session_in;
            noload_ff    <= noload_in;
            absent_ff    <= absent_in;
            atime_ff     <= atime_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

// ===== rtl/core/icfc_checker.sv =====
`timescale 1ns / 1ps

module icfc_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input icfc_pkg::rsp_type rsp_data
);
   import icfc_pkg::*;

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.input_enabled == (rsp_data.applied_limit != 9'd0))
      else $error("enable does not match applied limit");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.input_enabled |->
         rsp_data.applied_limit == LIM_MIN + {1'b0, rsp_data.limit_code} * 9'd2)
      else $error("limit code off grid");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error_code != ERR_NONE |->
         !rsp_data.input_enabled && rsp_data.loop_state == STATE_IDLE &&
         rsp_data.report_status == 2'd0 && rsp_data.report_vbus == 8'd0 &&
         rsp_data.report_ibus == 8'd0 && !rsp_data.fast_poll)
      else $error("error tick left input on or reported readings");

endmodule

bind input_current_foldback_controller_unit icfc_checker u_icfc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== tb/input_current_foldback_controller_unit_tb.sv =====
`timescale 1ns / 1ps

module input_current_foldback_controller_unit_tb;
   import icfc_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_NOLOAD   = 3'd1,
      PH_PROBE    = 3'd2,
      PH_DEBOUNCE = 3'd3,
      PH_SETTLE   = 3'd4
   } loop_phase_type;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 4;
   localparam int PRINT_CAP      = 100;

   logic        clock        = 1'b0;
   logic        reset        = 1'b1;
   logic        req_valid    = 1'b0;
   logic        req_stall;
   req_type     req_data     = '0;
   logic        rsp_valid;
   logic        rsp_stall    = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write_en = 1'b0;
   logic [1:0]  csr_index    = REG_MAX_INPUT_CODE;
   logic [15:0] csr_wdata    = '0;

   // register mirror
   logic [7:0]  max_code_reg = MAX_CODE_RST;
   logic [7:0]  droop_reg    = DROOP_RST;
   logic [7:0]  min_vbus_reg = MIN_VBUS_RST;
   logic [15:0] detach_reg   = DETACH_MS_RST;

   // foldback loop state
   loop_phase_type phase_q    = PH_IDLE;
   int          target_q      = 0;
   int          applied_q     = 0;
   int          session_max_q = 0;
   int          noload_vbus_q = 0;
   logic        absent_q      = 1'b0;
   int          absent_ms_q   = 0;

   req_type tick_q[$];
   rsp_type expect_q[$];

   int mismatch_count = 0;
   int ticks_checked  = 0;
   int settle_seen    = 0;
   int fault_seen     = 0;
   int idle_pct       = 0;
   int send_hold      = 0;
   int recv_hold      = 0;
   int quiet_cycles   = 0;

   input_current_foldback_controller_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int max_code_units(logic [7:0] code);
      int c;
      c = code;
      if (c < CODE_LO) c = CODE_LO;
      if (c > CODE_HI) c = CODE_HI;
      return LIM_MIN + 2 * c;
   endfunction

   function automatic void set_applied(int want);
      if (want == 0) begin
         applied_q = 0;
      end else begin
         if (want < LIM_MIN) want = LIM_MIN;
         if (want > LIM_HWMAX) want = LIM_HWMAX;
         applied_q = LIM_MIN + ((want - LIM_MIN) / 2) * 2;
      end
   endfunction

   function automatic logic vbus_drooped(int v);
      return noload_vbus_q > v && (noload_vbus_q - v) > droop_reg;
   endfunction

   function automatic void step_down();
      int want;
      if (target_q <= LIM_MIN) begin
         want = 0;
      end else begin
         want = target_q - LIM_STEP;
         if (want < LIM_MIN) want = LIM_MIN;
      end
      set_applied(want);
      target_q = want;
   endfunction

   function automatic void note_absence(int el);
      absent_ms_q = absent_ms_q + el > 65535 ? 65535 : absent_ms_q + el;
      if (absent_ms_q > detach_reg) session_max_q = max_code_units(max_code_reg);
   endfunction

   function automatic rsp_type predict_tick(req_type t);
      rsp_type    r;
      logic       failed;
      logic       fast;
      logic [1:0] err;
      int         v;
      r      = '0;
      failed = 1'b0;
      fast   = 1'b0;
      err    = ERR_NONE;
      v      = t.vbus_code;
      if (t.access_error) begin
         failed = 1'b1;
         err    = ERR_ACCESS;
      end else if (!t.vbus_present) begin
         applied_q = 0;
         phase_q   = PH_IDLE;
         target_q  = 0;
         if (!absent_q) begin
            absent_q    = 1'b1;
            absent_ms_q = 0;
         end else begin
            note_absence(t.elapsed_ms);
         end
         r.report_status = {t.charging_bit, 1'b0};
      end else begin
         if (absent_q) note_absence(t.elapsed_ms);
         absent_q = 1'b0;
         r.report_status = {t.charging_bit, 1'b1};
         if (phase_q != PH_IDLE) begin
            if (v < min_vbus_reg) begin
               failed = 1'b1;
               err    = ERR_VBUS_LOW;
            end else begin
               r.report_vbus = t.vbus_code;
               if (phase_q != PH_NOLOAD) r.report_ibus = t.ibus_code;
            end
         end
         if (!failed) begin
            fast = 1'b1;
            case (phase_q)
               PH_NOLOAD: begin
                  noload_vbus_q = v;
                  target_q = session_max_q < LIM_START ? session_max_q : LIM_START;
                  set_applied(target_q);
                  phase_q = PH_PROBE;
               end
               PH_PROBE: begin
                  if (vbus_drooped(v)) begin
                     phase_q = PH_DEBOUNCE;
                  end else if (applied_q >= session_max_q) begin
                     phase_q = PH_SETTLE;
                  end else begin
                     target_q = target_q + LIM_STEP > session_max_q ?
                                session_max_q : target_q + LIM_STEP;
                     set_applied(target_q);
                  end
               end
               PH_DEBOUNCE: begin
                  if (vbus_drooped(v)) begin
                     step_down();
                     phase_q = applied_q != 0 ? PH_SETTLE : PH_NOLOAD;
                  end else begin
                     phase_q = PH_PROBE;
                  end
               end
               PH_SETTLE: begin
                  fast = 1'b0;
                  if (vbus_drooped(v)) begin
                     step_down();
                     if (applied_q == 0) phase_q = PH_NOLOAD;
                  end else if (target_q != 0 && target_q < session_max_q) begin
                     session_max_q = target_q;
                  end
               end
               default: begin
                  applied_q = 0;
                  phase_q   = PH_NOLOAD;
               end
            endcase
         end
      end
      if (failed) begin
         applied_q = 0;
         phase_q   = PH_IDLE;
         target_q  = 0;
         r         = '0;
      end
      r.error_code    = err;
      r.input_enabled = applied_q != 0;
      r.limit_code    = applied_q != 0 ? 8'((applied_q - LIM_MIN) / 2) : 8'd0;
      r.applied_limit = 9'(applied_q);
      r.loop_state    = phase_q;
      r.fast_poll     = fast;
      return r;
   endfunction

   task automatic report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP) $display("[%0t] MISMATCH %s", $time, what);
   endtask

   task automatic check_field(string name, int got, int want);
      if (got != want)
         report_mismatch($sformatf("tick %0d %s: got %0d, expected %0d",
                                   ticks_checked, name, got, want));
   endtask

   // driver: present queued ticks, hold payload while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) expect_q.push_back(predict_tick(req_data));
         if (!req_valid || !req_stall) begin
            if (send_hold > 0) begin
               send_hold--;
               req_valid <= 1'b0;
            end else if (tick_q.size() > 0) begin
               req_data  <= tick_q.pop_front();
               req_valid <= 1'b1;
               if ($urandom_range(0, 99) < idle_pct) send_hold = $urandom_range(1, 18);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each transfer against the oldest expected result
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expect_q.size() == 0) begin
               report_mismatch("result transfer with no tick outstanding");
            end else begin
               want = expect_q.pop_front();
               check_field("input_enabled", rsp_data.input_enabled, want.input_enabled);
               check_field("limit_code", rsp_data.limit_code, want.limit_code);
               check_field("applied_limit", rsp_data.applied_limit, want.applied_limit);
               check_field("loop_state", rsp_data.loop_state, want.loop_state);
               check_field("fast_poll", rsp_data.fast_poll, want.fast_poll);
               check_field("error_code", rsp_data.error_code, want.error_code);
               check_field("report_vbus", rsp_data.report_vbus, want.report_vbus);
               check_field("report_ibus", rsp_data.report_ibus, want.report_ibus);
               check_field("report_status", rsp_data.report_status, want.report_status);
               if (want.loop_state == PH_SETTLE) settle_seen++;
               if (want.error_code != ERR_NONE) fault_seen++;
               ticks_checked++;
            end
         end
         if (recv_hold > 0) begin
            recv_hold--;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(0, 99) < idle_pct) begin
            recv_hold = $urandom_range(0, 17);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no transfer in %0d cycles", WATCHDOG_LIMIT);
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_type tick_of(logic vp, logic chg, logic [7:0] v, logic [7:0] ib,
                                       logic err, logic [15:0] el);
      req_type t;
      t.vbus_present = vp;
      t.charging_bit = chg;
      t.vbus_code    = v;
      t.ibus_code    = ib;
      t.access_error = err;
      t.elapsed_ms   = el;
      return t;
   endfunction

   function automatic req_type rand_tick();
      req_type t;
      t.vbus_present = 1'b1;
      t.charging_bit = 1'($urandom);
      t.vbus_code    = 8'($urandom);
      t.ibus_code    = 8'($urandom);
      t.access_error = 1'b0;
      t.elapsed_ms   = $urandom_range(0, 3) != 0 ? 16'($urandom_range(100, 2000)) :
                                                   16'($urandom);
      return t;
   endfunction

   task automatic write_reg(logic [1:0] idx, logic [15:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         REG_MAX_INPUT_CODE:  max_code_reg = value[7:0];
         REG_DROOP_THRESHOLD: droop_reg    = value[7:0];
         REG_MIN_VBUS_CODE:   min_vbus_reg = value[7:0];
         default:             detach_reg   = value;
      endcase
   endtask

   task automatic program_regs(logic [7:0] max_code, logic [7:0] droop,
                               logic [7:0] min_vbus, logic [15:0] detach);
      logic [7:0] junk;
      junk = 8'($urandom);
      write_reg(REG_MAX_INPUT_CODE, {junk, max_code});
      junk = 8'($urandom);
      write_reg(REG_DROOP_THRESHOLD, {junk, droop});
      junk = 8'($urandom);
      write_reg(REG_MIN_VBUS_CODE, {junk, min_vbus});
      write_reg(REG_DETACH_MS, detach);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (tick_q.size() != 0 || req_valid || expect_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // sessions of plausible VBUS readings around a nominal level, with unplug
   // bursts, droops, faults and noise mixed in
   task automatic random_ticks(int count);
      int      added;
      int      len;
      int      nominal;
      int      droop_pct;
      int      sel;
      int      dv;
      req_type t;
      added = 0;
      while (added < count) begin
         nominal   = $urandom_range(min_vbus_reg, 255);
         droop_pct = $urandom_range(0, 2) * 20;
         len       = $urandom_range(5, 90);
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 4)) begin
               t = rand_tick();
               t.vbus_present = 1'b0;
               if ($urandom_range(0, 1) != 0)
                  t.elapsed_ms = 16'($urandom_range(0, detach_reg / 2 + 1));
               tick_q.push_back(t);
               added++;
            end
         end
         for (int i = 0; i < len && added < count; i++) begin
            t   = rand_tick();
            sel = $urandom_range(0, 99);
            if (sel < 2) begin
               t.access_error = 1'b1;
            end else if (sel < 4) begin
               t.vbus_present = 1'b0;
            end else if (sel >= 7 && sel < 7 + droop_pct) begin
               dv = droop_reg + 1 + $urandom_range(0, 20);
               t.vbus_code = nominal > dv ? 8'(nominal - dv) : 8'd0;
            end else if (sel >= 7) begin
               dv = $urandom_range(0, droop_reg);
               t.vbus_code = 8'(nominal - (dv > nominal ? nominal : dv));
            end
            tick_q.push_back(t);
            added++;
         end
      end
   endtask

   initial begin
      session_max_q = max_code_units(max_code_reg);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      idle_pct = 5;

      tick_q.push_back(tick_of(1, 1, 255, 255, 1, 16'hFFFF));
      tick_q.push_back(tick_of(0, 1, 0, 0, 0, 0));
      tick_q.push_back(tick_of(0, 0, 255, 255, 0, 16'hFFFF));
      tick_q.push_back(tick_of(0, 0, 0, 0, 0, 16'hFFFF));
      tick_q.push_back(tick_of(1, 1, 200, 0, 0, 16'hFFFF));
      tick_q.push_back(tick_of(1, 0, 200, 255, 0, 300));
      tick_q.push_back(tick_of(1, 1, 200, 128, 0, 300));
      tick_q.push_back(tick_of(1, 0, 199, 1, 0, 300));
      tick_q.push_back(tick_of(1, 0, 183, 1, 0, 300));
      tick_q.push_back(tick_of(1, 0, 184, 2, 0, 300));
      tick_q.push_back(tick_of(1, 1, 159, 3, 0, 300));
      tick_q.push_back(tick_of(1, 0, 200, 4, 0, 2000));
      tick_q.push_back(tick_of(1, 0, 220, 5, 0, 300));
      tick_q.push_back(tick_of(1, 0, 203, 6, 0, 300));
      tick_q.push_back(tick_of(1, 0, 210, 7, 0, 300));
      tick_q.push_back(tick_of(1, 0, 220, 8, 0, 300));
      tick_q.push_back(tick_of(1, 0, 200, 9, 0, 300));
      tick_q.push_back(tick_of(1, 0, 200, 10, 0, 300));
      tick_q.push_back(tick_of(1, 1, 255, 11, 0, 2000));
      tick_q.push_back(tick_of(0, 1, 100, 12, 0, 0));
      tick_q.push_back(tick_of(1, 0, 230, 13, 0, 100));
      random_ticks(150);

      for (int p = 0; p < 6; p++) begin
         wait_drained();
         case (p)
            0: program_regs(CODE_HI, 8'd0, 8'd0, 16'd0);
            1: program_regs(8'd255, 8'd255, 8'd255, 16'hFFFF);
            2: program_regs(8'd0, 8'd8, 8'd100, 16'd300);
            3: program_regs(8'd120, 8'd30, 8'd60, 16'd2000);
            4: program_regs(8'($urandom), 8'($urandom), 8'($urandom_range(0, 200)),
                            16'($urandom));
            default: program_regs(8'($urandom_range(150, 191)), 8'($urandom_range(5, 40)),
                                  8'($urandom_range(0, 150)), 16'($urandom_range(0, 3000)));
         endcase
         idle_pct = p == 5 ? 0 : (p % 3) * 4;
         random_ticks(125);
      end

      wait_drained();
      $display("Checked %0d poll ticks under 7 register settings,", ticks_checked);
      $display("%0d of them in settle and %0d with an error code.", settle_seen, fault_seen);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
